### rtl/core/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg
// shared constants, types and lookup function of the html entity decoder
// ----------------------------------------------------------------------------
package hed_pkg;

    localparam int WINDOW_SPAN_DEF = 16;

    // character codes
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // utf-8 encoding limits and marks
    localparam logic [16:0] UTF_ONE_LIMIT = 17'd128;
    localparam logic [16:0] UTF_TWO_MAX   = 17'h007FF;
    localparam logic [16:0] UTF_MAX       = 17'h0FFFF;
    localparam logic [16:0] MAG_SAT       = 17'h10000;
    localparam logic [7:0]  UTF_LEAD2     = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3     = 8'hE0;
    localparam logic [7:0]  UTF_CONT      = 8'h80;
    localparam logic [7:0]  UTF_CONT_MASK = 8'h3F;

    // named entities: text packed msb first, length, replacement glyph
    localparam int NAME_NUM = 6;
    localparam logic [31:0] NAME_TEXT [NAME_NUM] = '{
        32'h616D_7000, // amp
        32'h6C74_0000, // lt
        32'h6774_0000, // gt
        32'h7175_6F74, // quot
        32'h6170_6F73, // apos
        32'h6E62_7370  // nbsp
    };
    localparam logic [2:0] NAME_LEN [NAME_NUM] = '{3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4};
    localparam logic [7:0] NAME_GLYPH [NAME_NUM] = '{
        8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h20
    };

    function automatic logic [7:0] name_char(input int sel, input logic [1:0] pos);
        logic [31:0] text;
        text = NAME_TEXT[sel];
        return text[8*(3 - int'(pos)) +: 8];
    endfunction

    // source of a result byte
    typedef enum logic [2:0] {
        SRC_INPUT,
        SRC_PEND,
        SRC_RAM,
        SRC_AMP,
        SRC_SEMI,
        SRC_NAMED,
        SRC_UTF
    } out_src_t;

    // controller to datapath commands
    typedef struct packed {
        logic     latch;
        logic     set_open;
        logic     close;
        logic     append;
        logic     idx_clr;
        logic     idx_inc;
        logic     rd_en;
        logic     parse_init;
        logic     parse_step;
        logic     pend_amp;
        logic     pend_ram;
        logic     shift;
        logic     out_load;
        out_src_t out_src;
        logic     out_last;
    } hed_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_amp;
        logic is_semi;
        logic fin;
        logic open;
        logic full_next;
        logic idx_lt_cnt;
        logic rd_amp;
        logic named;
        logic numeric;
        logic utf_last;
        logic out_free;
    } hed_stat_t;

endpackage

### rtl/core/html_entity_decoder_unit.sv
// ----------------------------------------------------------------------------
// html_entity_decoder_unit
// path: a plain byte goes through the dispatch and emit states into the
//   result register; an entity is buffered, parsed and its bytes emitted
// flow: the sequencer holds text_stall until it has dispatched and emitted
//   each item; window parse and rescan read the window ram a byte at a
//   time through its registered read port
// reset: rst_n clears the window state and the result valid flag at once; the
//   window ram itself is not cleared, only written entries are ever read
// ----------------------------------------------------------------------------
module html_entity_decoder_unit
    import hed_pkg::*;
#(
    parameter int WINDOW_SPAN = WINDOW_SPAN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // text input channel
    input  logic       text_valid,
    output logic       text_stall,
    input  logic [7:0] text_byte,
    input  logic       final_byte,
    // decoded output channel
    output logic       decoded_valid,
    input  logic       decoded_stall,
    output logic [7:0] decoded_byte,
    output logic       run_last,
    output logic       text_done
);

    // command and status between sequencer and datapath
    hed_cmd_t  cmd;
    hed_stat_t stat;

    // sequencer: one item at a time, from dispatch to its last result
    hed_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // datapath: circular entity window in ram, streaming parser, utf-8
    // encoder and a result register that decouples the output stall
    hed_datapath #(
        .WINDOW_SPAN (WINDOW_SPAN)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .text_byte     (text_byte),
        .final_byte    (final_byte),
        .decoded_valid (decoded_valid),
        .decoded_stall (decoded_stall),
        .decoded_byte  (decoded_byte),
        .run_last      (run_last),
        .text_done     (text_done)
    );

endmodule

### rtl/core/hed_ram.sv
// ----------------------------------------------------------------------------
// hed_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module hed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/hed_datapath.sv
// ----------------------------------------------------------------------------
// hed_datapath
// entity window, numeric parser, name matcher, utf-8 encoder and result register
// ----------------------------------------------------------------------------
module hed_datapath
    import hed_pkg::*;
#(
    parameter int WINDOW_SPAN = WINDOW_SPAN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  hed_cmd_t   cmd,
    output hed_stat_t  stat,
    input  logic [7:0] text_byte,
    input  logic       final_byte,
    output logic       decoded_valid,
    input  logic       decoded_stall,
    output logic [7:0] decoded_byte,
    output logic       run_last,
    output logic       text_done
);

    localparam int AW = $clog2(WINDOW_SPAN);
    localparam int CW = $clog2(WINDOW_SPAN + 1);

    typedef enum logic [2:0] {
        P_HASH,
        P_BASE,
        P_BLANK,
        P_FIRST,
        P_ZERO,
        P_PFX,
        P_DIGIT,
        P_STOP
    } phase_t;

    logic [7:0]    byte_reg;
    logic          fin_reg;
    logic          open_reg, open_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [7:0]    pend_reg;

    phase_t          phase_reg, phase_next;
    logic            base16_reg, base16_next;
    logic            neg_reg, neg_next;
    logic            isnum_reg, isnum_next;
    logic [16:0]     mag_reg, mag_next;
    logic [NAME_NUM-1:0] hit_reg, hit_next;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;
    logic          out_done_reg;

    logic [AW-1:0] wr_addr, rd_addr, shift_addr;
    logic [CW:0]   wr_sum, rd_sum, shift_sum;
    logic [7:0]    rd_data;

    // byte classes of the window byte under the parser
    logic          c_ws, c_x, c_sign, c_dec, c_hex, d_ok;
    logic [3:0]    dval;
    logic [20:0]   acc;
    logic [16:0]   acc_sat;

    logic [16:0]   num_val;
    logic          num_bad;
    logic [1:0]    utf_len;
    logic [7:0]    utf_byte;
    logic [NAME_NUM-1:0] named_vec;
    logic [7:0]    glyph;
    logic [7:0]    out_mux;

    // circular window addressing
    always_comb
    begin
        wr_sum    = (CW+1)'(head_reg) + (CW+1)'(count_reg);
        rd_sum    = (CW+1)'(head_reg) + (CW+1)'(idx_reg);
        shift_sum = rd_sum + (CW+1)'(1);
        wr_addr    = (wr_sum >= (CW+1)'(WINDOW_SPAN)) ?
                     AW'(wr_sum - (CW+1)'(WINDOW_SPAN)) : AW'(wr_sum);
        rd_addr    = (rd_sum >= (CW+1)'(WINDOW_SPAN)) ?
                     AW'(rd_sum - (CW+1)'(WINDOW_SPAN)) : AW'(rd_sum);
        shift_addr = (shift_sum >= (CW+1)'(WINDOW_SPAN)) ?
                     AW'(shift_sum - (CW+1)'(WINDOW_SPAN)) : AW'(shift_sum);
    end

    hed_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_SPAN)
    ) u_window (
        .clk     (clk),
        .wr_en   (cmd.append),
        .wr_addr (wr_addr),
        .wr_data (byte_reg),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // window control state
    always_comb
    begin
        open_next  = open_reg;
        count_next = count_reg;
        head_next  = head_reg;
        idx_next   = idx_reg;
        if (cmd.set_open || cmd.close)
        begin
            open_next  = cmd.set_open;
            count_next = '0;
            head_next  = '0;
        end
        else if (cmd.append)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.shift)
        begin
            head_next  = shift_addr;
            count_next = count_reg - idx_reg - CW'(1);
        end
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            count_reg <= '0;
            head_reg  <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            open_reg  <= open_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            idx_reg   <= idx_next;
            if (cmd.latch)
            begin
                fin_reg <= final_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            byte_reg <= text_byte;
        end
        if (cmd.pend_amp)
        begin
            pend_reg <= CH_AMP;
        end
        else if (cmd.pend_ram)
        begin
            pend_reg <= rd_data;
        end
    end

    // byte classification for the parser
    always_comb
    begin
        c_ws   = (rd_data == CH_SPACE) || (rd_data >= CH_TAB && rd_data <= CH_CR);
        c_x    = (rd_data == CH_LOW_X) || (rd_data == CH_UP_X);
        c_sign = (rd_data == CH_PLUS) || (rd_data == CH_MINUS);
        c_dec  = (rd_data >= CH_ZERO) && (rd_data <= CH_NINE);
        c_hex  = c_dec || (rd_data >= CH_LOW_A && rd_data <= CH_LOW_F) ||
                 (rd_data >= CH_UP_A && rd_data <= CH_UP_F);
        if (c_dec)
        begin
            dval = rd_data[3:0];
        end
        else
        begin
            dval = rd_data[3:0] + 4'd9;
        end
        d_ok = base16_reg ? c_hex : c_dec;
        if (base16_reg)
        begin
            acc = {mag_reg, 4'b0000} + 21'(dval);
        end
        else
        begin
            acc = 21'({mag_reg, 3'b000}) + 21'({mag_reg, 1'b0}) + 21'(dval);
        end
        acc_sat = (acc > 21'(UTF_MAX)) ? MAG_SAT : acc[16:0];
    end

    // streaming numeric parser and name matcher
    always_comb
    begin
        logic do_blank;
        logic do_sign;
        logic do_first;
        logic do_digit;
        do_blank    = 1'b0;
        do_sign     = 1'b0;
        do_first    = 1'b0;
        do_digit    = 1'b0;
        phase_next  = phase_reg;
        base16_next = base16_reg;
        neg_next    = neg_reg;
        isnum_next  = isnum_reg;
        mag_next    = mag_reg;
        hit_next    = hit_reg;
        if (cmd.parse_init)
        begin
            phase_next  = P_HASH;
            base16_next = 1'b0;
            neg_next    = 1'b0;
            isnum_next  = 1'b0;
            mag_next    = '0;
            hit_next    = '1;
        end
        else if (cmd.parse_step)
        begin
            for (int i = 0; i < NAME_NUM; i++)
            begin
                if (idx_reg >= CW'(NAME_LEN[i]) || rd_data != name_char(i, idx_reg[1:0]))
                begin
                    hit_next[i] = 1'b0;
                end
            end
            case (phase_reg)
                P_HASH:
                begin
                    isnum_next = (rd_data == CH_HASH);
                    phase_next = P_BASE;
                end
                P_BASE:
                begin
                    if (c_x)
                    begin
                        base16_next = 1'b1;
                        phase_next  = P_BLANK;
                    end
                    else
                    begin
                        do_blank = 1'b1;
                    end
                end
                P_BLANK: do_blank = 1'b1;
                P_FIRST: do_first = 1'b1;
                P_ZERO:
                begin
                    if (c_x)
                    begin
                        phase_next = P_PFX;
                    end
                    else
                    begin
                        do_digit = 1'b1;
                    end
                end
                P_PFX:
                begin
                    if (c_hex)
                    begin
                        mag_next   = 17'(dval);
                        phase_next = P_DIGIT;
                    end
                    else
                    begin
                        phase_next = P_STOP;
                    end
                end
                P_DIGIT: do_digit = 1'b1;
                P_STOP:  phase_next = P_STOP;
                default: phase_next = P_STOP;
            endcase
            if (do_blank)
            begin
                if (c_ws)
                begin
                    phase_next = P_BLANK;
                end
                else
                begin
                    do_sign = 1'b1;
                end
            end
            if (do_sign)
            begin
                if (c_sign)
                begin
                    neg_next   = (rd_data == CH_MINUS);
                    phase_next = P_FIRST;
                end
                else
                begin
                    do_first = 1'b1;
                end
            end
            if (do_first)
            begin
                // a leading zero in hex may open a 0x prefix
                if (base16_reg && rd_data == CH_ZERO)
                begin
                    phase_next = P_ZERO;
                end
                else
                begin
                    do_digit = 1'b1;
                end
            end
            if (do_digit)
            begin
                if (d_ok)
                begin
                    mag_next   = acc_sat;
                    phase_next = P_DIGIT;
                end
                else
                begin
                    phase_next = P_STOP;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= P_HASH;
            base16_reg <= 1'b0;
            neg_reg    <= 1'b0;
            isnum_reg  <= 1'b0;
            mag_reg    <= '0;
            hit_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            base16_reg <= base16_next;
            neg_reg    <= neg_next;
            isnum_reg  <= isnum_next;
            mag_reg    <= mag_next;
            hit_reg    <= hit_next;
        end
    end

    // named entity result
    always_comb
    begin
        glyph = CH_QMARK;
        for (int i = NAME_NUM - 1; i >= 0; i--)
        begin
            named_vec[i] = hit_reg[i] && (count_reg == CW'(NAME_LEN[i]));
            if (named_vec[i])
            begin
                glyph = NAME_GLYPH[i];
            end
        end
    end

    // utf-8 encoding of the numeric value
    always_comb
    begin
        num_val = neg_reg ? '0 : mag_reg;
        num_bad = (num_val == '0) || (num_val > UTF_MAX);
        if (num_bad || num_val < UTF_ONE_LIMIT)
        begin
            utf_len = 2'd1;
        end
        else if (num_val <= UTF_TWO_MAX)
        begin
            utf_len = 2'd2;
        end
        else
        begin
            utf_len = 2'd3;
        end
        case (utf_len)
            2'd1: utf_byte = num_bad ? CH_QMARK : num_val[7:0];
            2'd2:
            begin
                if (idx_reg == '0)
                begin
                    utf_byte = UTF_LEAD2 | 8'(num_val[10:6]);
                end
                else
                begin
                    utf_byte = UTF_CONT | (num_val[7:0] & UTF_CONT_MASK);
                end
            end
            default:
            begin
                if (idx_reg == '0)
                begin
                    utf_byte = UTF_LEAD3 | 8'(num_val[15:12]);
                end
                else if (idx_reg == CW'(1))
                begin
                    utf_byte = UTF_CONT | (8'(num_val[11:6]) & UTF_CONT_MASK);
                end
                else
                begin
                    utf_byte = UTF_CONT | (num_val[7:0] & UTF_CONT_MASK);
                end
            end
        endcase
    end

    // result register
    always_comb
    begin
        case (cmd.out_src)
            SRC_INPUT: out_mux = byte_reg;
            SRC_PEND:  out_mux = pend_reg;
            SRC_RAM:   out_mux = rd_data;
            SRC_AMP:   out_mux = CH_AMP;
            SRC_SEMI:  out_mux = CH_SEMI;
            SRC_NAMED: out_mux = glyph;
            SRC_UTF:   out_mux = utf_byte;
            default:   out_mux = CH_QMARK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!decoded_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_byte_reg <= out_mux;
            out_last_reg <= cmd.out_last;
            out_done_reg <= cmd.out_last && fin_reg;
        end
    end

    assign decoded_valid = out_valid_reg;
    assign decoded_byte  = out_byte_reg;
    assign run_last      = out_last_reg;
    assign text_done     = out_done_reg;

    always_comb
    begin
        stat.is_amp     = (byte_reg == CH_AMP);
        stat.is_semi    = (byte_reg == CH_SEMI);
        stat.fin        = fin_reg;
        stat.open       = open_reg;
        stat.full_next  = ((CW+1)'(count_reg) + (CW+1)'(1)) >= (CW+1)'(WINDOW_SPAN);
        stat.idx_lt_cnt = (idx_reg < count_reg);
        stat.rd_amp     = (rd_data == CH_AMP);
        stat.named      = |named_vec;
        stat.numeric    = isnum_reg;
        stat.utf_last   = (idx_reg == CW'(utf_len - 2'd1));
        stat.out_free   = !out_valid_reg || !decoded_stall;
    end

`ifndef SYNTH
    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> count_reg == '0)
        else $error("closed window holds bytes");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(WINDOW_SPAN))
        else $error("window count beyond span");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && decoded_stall))
        else $error("result overwritten while stalled");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |-> out_last_reg)
        else $error("text done without run last");
`endif

endmodule

### rtl/core/hed_ctrl.sv
// ----------------------------------------------------------------------------
// hed_ctrl
// sequencer for dispatch, window parse, decode emission and window rescan
// ----------------------------------------------------------------------------
module hed_ctrl
    import hed_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      text_valid,
    output logic      text_stall,
    input  hed_stat_t stat,
    output hed_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_EMIT_IN,
        S_PRD,
        S_PUSE,
        S_DECIDE,
        S_UTF,
        S_UNK_RD,
        S_UNK_USE,
        S_UNK_END,
        S_RSC_RD,
        S_RSC_USE,
        S_RSC_END
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_src = SRC_INPUT;
        unique case (state_reg)
            S_IDLE:
            begin
                if (text_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!stat.open)
                begin
                    if (stat.is_amp && !stat.fin)
                    begin
                        cmd.set_open = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EMIT_IN;
                    end
                end
                else if (stat.is_semi)
                begin
                    cmd.idx_clr    = 1'b1;
                    cmd.parse_init = 1'b1;
                    state_next     = S_PRD;
                end
                else
                begin
                    cmd.append = 1'b1;
                    if (stat.full_next || stat.fin)
                    begin
                        cmd.idx_clr  = 1'b1;
                        cmd.pend_amp = 1'b1;
                        state_next   = S_RSC_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMIT_IN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = SRC_INPUT;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_PRD:
            begin
                if (stat.idx_lt_cnt)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_PUSE;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_PUSE:
            begin
                cmd.parse_step = 1'b1;
                cmd.idx_inc    = 1'b1;
                state_next     = S_PRD;
            end
            S_DECIDE:
            begin
                if (stat.named)
                begin
                    if (stat.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_src  = SRC_NAMED;
                        cmd.out_last = 1'b1;
                        cmd.close    = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else if (stat.numeric)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_UTF;
                end
                else if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = SRC_AMP;
                    cmd.idx_clr  = 1'b1;
                    state_next   = S_UNK_RD;
                end
            end
            S_UTF:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = SRC_UTF;
                    cmd.out_last = stat.utf_last;
                    if (stat.utf_last)
                    begin
                        cmd.close  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_UNK_RD:
            begin
                if (stat.idx_lt_cnt)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_UNK_USE;
                end
                else
                begin
                    state_next = S_UNK_END;
                end
            end
            S_UNK_USE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = SRC_RAM;
                    cmd.idx_inc  = 1'b1;
                    state_next   = S_UNK_RD;
                end
            end
            S_UNK_END:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = SRC_SEMI;
                    cmd.out_last = 1'b1;
                    cmd.close    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_RSC_RD:
            begin
                if (stat.idx_lt_cnt)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_RSC_USE;
                end
                else
                begin
                    state_next = S_RSC_END;
                end
            end
            S_RSC_USE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = SRC_PEND;
                    // a buffered ampersand reopens the window after itself
                    if (!stat.fin && stat.rd_amp)
                    begin
                        cmd.out_last = 1'b1;
                        cmd.shift    = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cmd.pend_ram = 1'b1;
                        cmd.idx_inc  = 1'b1;
                        state_next   = S_RSC_RD;
                    end
                end
            end
            S_RSC_END:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = SRC_PEND;
                    cmd.out_last = 1'b1;
                    cmd.close    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign text_stall = (state_reg != S_IDLE);

endmodule
